### rtl/spaq_pkg.sv
// ----------------------------------------------------------------------------
// spaq_pkg
// Shared types and constants for the sorted array priority queue.
// ----------------------------------------------------------------------------
package spaq_pkg;

    localparam int DEPTH   = 64;
    localparam int CNT_W   = $clog2(DEPTH + 1);
    localparam int DATA_W  = 32;
    localparam int OCC_W   = 7;

    localparam logic REQ_ENQ = 1'b0;
    localparam logic REQ_DEQ = 1'b1;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_OVERFLOW  = 2'd1,
        ST_UNDERFLOW = 2'd2
    } t_status;

    typedef struct packed {
        logic                     req_type;
        logic signed [DATA_W-1:0] push_value;
    } t_req;

    typedef struct packed {
        logic [1:0]               status;
        logic signed [DATA_W-1:0] pop_value;
        logic [OCC_W-1:0]         occupancy;
    } t_rsp;

    typedef struct packed {
        logic                     enq;
        logic                     deq;
        logic signed [DATA_W-1:0] value;
    } t_cell_ctl;

endpackage

### rtl/spaq_cell.sv
// ----------------------------------------------------------------------------
// spaq_cell
// One storage cell of the sorted row, largest value at the head.
// ----------------------------------------------------------------------------
module spaq_cell
    import spaq_pkg::*;
(
    input  logic                     i_clk,
    input  t_cell_ctl                i_ctl,
    input  logic                     i_occupied,
    input  logic                     i_prev_gt,
    input  logic signed [DATA_W-1:0] i_prev_val,
    input  logic signed [DATA_W-1:0] i_next_val,
    output logic                     o_gt,
    output logic signed [DATA_W-1:0] o_val
);

    logic signed [DATA_W-1:0] r_val;
    logic signed [DATA_W-1:0] n_val;

    assign o_gt  = i_occupied && (r_val > i_ctl.value);
    assign o_val = r_val;

    always_comb begin
        n_val = r_val;
        if (i_ctl.enq && !o_gt) begin
            n_val = i_prev_gt ? i_ctl.value : i_prev_val;
        end else if (i_ctl.deq) begin
            n_val = i_next_val;
        end
    end

    always_ff @(posedge i_clk) begin
        r_val <= n_val;
    end

endmodule

### rtl/sorted_array_priority_queue_core.sv
// ----------------------------------------------------------------------------
// sorted_array_priority_queue_core
// Priority queue held in a row of cells kept sorted with the largest first.
//
// Channel   Direction  Handshake            Payload
// request   in         start && !busy       i_req  (t_req)
// result    out        o_rsp_valid strobe   o_rsp  (t_rsp)
//
// For each item, all cells compare against the new value and
// shift in the same cycle, and the result appears in the following cycle.
// Busy stays low, so a new item can be taken in every cycle.
// Reset clears the entry count and the result strobe; cell contents are not cleared.
// The receiver cannot stall; each result is shown for one cycle.
// ----------------------------------------------------------------------------
module sorted_array_priority_queue_core
    import spaq_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic start,
    input  t_req i_req,
    output logic busy,
    output logic o_rsp_valid,
    output t_rsp o_rsp
);

    logic                     w_accept;
    logic                     w_full;
    logic                     w_empty;
    logic                     w_do_enq;
    logic                     w_do_deq;
    t_cell_ctl                w_ctl;
    logic [CNT_W-1:0]         r_count;
    logic [CNT_W-1:0]         n_count;
    logic                     r_valid;
    t_rsp                     r_rsp;
    t_rsp                     n_rsp;
    logic                     w_gt       [DEPTH+1];
    logic signed [DATA_W-1:0] w_val      [DEPTH];
    logic signed [DATA_W-1:0] w_prev_val [DEPTH];
    logic signed [DATA_W-1:0] w_next_val [DEPTH];

    assign busy     = 1'b0;
    assign w_accept = start && !busy;
    assign w_full   = (r_count == CNT_W'(DEPTH));
    assign w_empty  = (r_count == '0);
    assign w_do_enq = w_accept && (i_req.req_type == REQ_ENQ) && !w_full;
    assign w_do_deq = w_accept && (i_req.req_type == REQ_DEQ) && !w_empty;

    assign w_ctl.enq   = w_do_enq;
    assign w_ctl.deq   = w_do_deq;
    assign w_ctl.value = i_req.push_value;

    assign w_gt[0] = 1'b1;

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        if (g == 0) begin : g_head
            assign w_prev_val[g] = w_val[g];
        end else begin : g_body
            assign w_prev_val[g] = w_val[g-1];
        end
        if (g == DEPTH - 1) begin : g_tail
            assign w_next_val[g] = w_val[g];
        end else begin : g_link
            assign w_next_val[g] = w_val[g+1];
        end

        spaq_cell u_cell (
            .i_clk      (i_clk),
            .i_ctl      (w_ctl),
            .i_occupied (CNT_W'(g) < r_count),
            .i_prev_gt  (w_gt[g]),
            .i_prev_val (w_prev_val[g]),
            .i_next_val (w_next_val[g]),
            .o_gt       (w_gt[g+1]),
            .o_val      (w_val[g])
        );
    end

    always_comb begin
        n_count = r_count;
        if (w_do_enq) begin
            n_count = r_count + CNT_W'(1);
        end else if (w_do_deq) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    always_comb begin
        n_rsp.status    = ST_OK;
        n_rsp.pop_value = '0;
        n_rsp.occupancy = OCC_W'(n_count);
        if (i_req.req_type == REQ_ENQ) begin
            if (w_full) begin
                n_rsp.status = ST_OVERFLOW;
            end
        end else if (w_empty) begin
            n_rsp.status    = ST_UNDERFLOW;
            n_rsp.pop_value = '1;
        end else begin
            n_rsp.pop_value = w_val[0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_valid <= 1'b0;
        end else begin
            r_count <= n_count;
            r_valid <= w_accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_rsp <= n_rsp;
        end
    end

    assign o_rsp_valid = r_valid;
    assign o_rsp       = r_rsp;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DEPTH))
        else $error("entry count exceeds the depth");

    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> o_rsp_valid && (o_rsp.occupancy == OCC_W'(r_count)))
        else $error("result missing or occupancy disagrees with the count");

    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_accept |=> !o_rsp_valid)
        else $error("result strobe without an accepted item");

    a_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp_valid && (o_rsp.status == ST_UNDERFLOW) |->
            (o_rsp.occupancy == '0) && (o_rsp.pop_value == '1))
        else $error("underflow result with stored entries");

endmodule
